@@ hw/rtl/dvfs_gov_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DVFS governor package
// Shared types, register indexes and constants of the load-based governor.
// ----------------------------------------------------------------------------
package dvfs_gov_pkg;

	localparam int FREQ_W     = 23;
	localparam int LOAD_W     = 7;
	localparam int CNT_W      = 64;
	localparam int DELTA_W    = 32;
	localparam int NUM_W      = 39;	// 100 * 32-bit delta
	localparam int DIV_CNT_W  = $clog2(NUM_W);
	localparam int STEP_W     = 10;	// signed step count, -227..227
	localparam int PROD_W     = 23;	// signed step * 3780
	localparam int TGT_W      = 25;	// signed unclamped target
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 23;
	localparam int IN_DATA_W  = 200;
	localparam int OUT_DATA_W = 40;

	localparam logic [12:0] STEP_KHZ           = 13'd3780;
	localparam logic [6:0]  PERCENT_FULL       = 7'd100;
	localparam logic [6:0]  HIGH_BAND_DEC_STEP = 7'd10;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_UP_LOAD_LOW_BAND   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UP_LOAD            = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DOWN_LOAD          = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UP_OFFSET_LOW_BAND = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UP_OFFSET          = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DOWN_OFFSET        = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_BAND_FREQ      = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_BAND_FREQ     = 3'd7;

	// Action codes of a result item.
	localparam logic [1:0] ACT_HOLD     = 2'd0;
	localparam logic [1:0] ACT_INCREASE = 2'd1;
	localparam logic [1:0] ACT_DECREASE = 2'd2;

	typedef struct packed {
		logic [LOAD_W-1:0]  up_load_low_band;
		logic [LOAD_W-1:0]  up_load;
		logic [LOAD_W-1:0]  down_load;
		logic signed [7:0]  up_offset_low_band;
		logic signed [7:0]  up_offset;
		logic [LOAD_W-1:0]  down_offset;
		logic [FREQ_W-1:0]  low_band_freq;
		logic [FREQ_W-1:0]  high_band_freq;
	} cfg_regs_t;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_PREP  = 8'b0000_0010,
		ST_DIV   = 8'b0000_0100,
		ST_DEC   = 8'b0000_1000,
		ST_MUL   = 8'b0001_0000,
		ST_ADD   = 8'b0010_0000,
		ST_CLAMP = 8'b0100_0000,
		ST_OUT   = 8'b1000_0000
	} gov_state_t;

endpackage

@@ hw/rtl/dvfs_gov_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DVFS governor configuration registers
// Holds the threshold, offset and band registers written over the cfg port.
// ----------------------------------------------------------------------------
module dvfs_gov_cfg
	import dvfs_gov_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_regs_t             regs
);

	cfg_regs_t regs_q;

	assign cfg_ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.up_load_low_band   <= 7'd40;
			regs_q.up_load            <= 7'd60;
			regs_q.down_load          <= 7'd60;
			regs_q.up_offset_low_band <= 8'sd0;
			regs_q.up_offset          <= 8'sd20;
			regs_q.down_offset        <= 7'd10;
			regs_q.low_band_freq      <= 23'd1728000;
			regs_q.high_band_freq     <= 23'd2265600;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_UP_LOAD_LOW_BAND:   regs_q.up_load_low_band   <= cfg_data[6:0];
				REG_UP_LOAD:            regs_q.up_load            <= cfg_data[6:0];
				REG_DOWN_LOAD:          regs_q.down_load          <= cfg_data[6:0];
				REG_UP_OFFSET_LOW_BAND: regs_q.up_offset_low_band <= $signed(cfg_data[7:0]);
				REG_UP_OFFSET:          regs_q.up_offset          <= $signed(cfg_data[7:0]);
				REG_DOWN_OFFSET:        regs_q.down_offset        <= cfg_data[6:0];
				REG_LOW_BAND_FREQ:      regs_q.low_band_freq      <= cfg_data;
				REG_HIGH_BAND_FREQ:     regs_q.high_band_freq     <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

@@ hw/rtl/dvfs_gov_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DVFS governor serial divider
// Restoring divider, one quotient bit per cycle, for the load percentage.
// ----------------------------------------------------------------------------
module dvfs_gov_div
	import dvfs_gov_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [NUM_W-1:0]   num,
	input  logic [DELTA_W-1:0] den,
	output logic               done,
	output logic [LOAD_W-1:0]  quot
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0]     num_q;
	logic [DELTA_W-1:0]   den_q;
	logic [DELTA_W-1:0]   rem_q;
	logic [LOAD_W-1:0]    quot_q;

	logic [DELTA_W:0]     rem_sh;
	logic                 fits;

	// The caller guarantees a quotient of at most 100, so only the low
	// quotient bits are kept.
	assign rem_sh = {rem_q, num_q[NUM_W-1]};
	assign fits   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(NUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= num;
			den_q  <= den;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q  <= {num_q[NUM_W-2:0], 1'b0};
			rem_q  <= fits ? DELTA_W'(rem_sh - {1'b0, den_q}) : rem_sh[DELTA_W-1:0];
			quot_q <= {quot_q[LOAD_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

	assert property (@(posedge clk) disable iff (!arst_n) start |=> busy_q && !done_q)
		else $error("divider did not start");
	assert property (@(posedge clk) disable iff (!arst_n) start |-> !busy_q)
		else $error("divider restarted while busy");
	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> !busy_q)
		else $error("divider done while busy");

endmodule

@@ hw/rtl/load_based_dvfs_governor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load-based DVFS governor
// One frequency decision per sample of cumulative wall and idle counters.
// ----------------------------------------------------------------------------
// A sample is taken only while the block is idle. Its result item then passes
// through the delta check, the serial divider that forms the load percentage,
// one quotient bit per cycle, and the decision; when the frequency steps, the
// step multiply, add and clamp follow before the output state. A sample with
// a zero or inconsistent delta goes from the delta check straight to the
// output state. The counters of every sample, valid or not, become the new
// previous counters. The next sample is taken once the result has moved into
// the output register, even while that result still waits for m_tready.
module load_based_dvfs_governor
	import dvfs_gov_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// wall_now[63:0], idle_now[127:64], cur_freq[150:128], min_freq[173:151],
	// max_freq[196:174], zero fill [199:197]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// sample_ok[0], load_percent[7:1], action[9:8], target_freq[32:10],
	// zero fill [39:33]
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_regs_t  regs;
	gov_state_t state_q;

	logic [CNT_W-1:0]   prev_wall_q;
	logic [CNT_W-1:0]   prev_idle_q;
	logic [DELTA_W-1:0] wall_q;
	logic [DELTA_W-1:0] idle_q;
	logic [FREQ_W-1:0]  cur_q;
	logic [FREQ_W-1:0]  min_q;
	logic [FREQ_W-1:0]  max_q;
	logic [LOAD_W-1:0]  load_q;
	logic [1:0]         act_q;
	logic signed [STEP_W-1:0] step_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [TGT_W-1:0]  tgt_q;
	logic [FREQ_W-1:0]  res_freq_q;
	logic               res_ok_q;

	logic               out_valid_q;
	logic               out_ok_q;
	logic [LOAD_W-1:0]  out_load_q;
	logic [1:0]         out_act_q;
	logic [FREQ_W-1:0]  out_freq_q;

	logic               in_acc;
	logic               out_free;
	logic [DELTA_W-1:0] busy_d;
	logic [NUM_W-1:0]   num_d;
	logic               bad_d;
	logic               div_done;
	logic [LOAD_W-1:0]  div_quot;

	logic               low_band;
	logic               high_band;
	logic [LOAD_W-1:0]  inc_th;
	logic signed [7:0]  up_off;
	logic [LOAD_W-1:0]  dec_add;
	logic               go_up;
	logic               go_down;
	logic signed [STEP_W-1:0] up_s;
	logic signed [STEP_W-1:0] down_s;
	logic signed [PROD_W-1:0] prod_d;
	logic signed [TGT_W-1:0]  tgt_max;
	logic signed [TGT_W-1:0]  tgt_lim;

	dvfs_gov_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	dvfs_gov_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_PREP && !bad_d),
		.num    (num_d),
		.den    (wall_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	// Delta check and 100 * busy time, built from shifts.
	assign bad_d  = (wall_q == '0) || (wall_q < idle_q);
	assign busy_d = wall_q - idle_q;
	assign num_d  = ({7'd0, busy_d} << 6) + ({7'd0, busy_d} << 5) + ({7'd0, busy_d} << 2);

	// Band selection and step counts.
	assign low_band  = cur_q < regs.low_band_freq;
	assign high_band = !low_band && (cur_q > regs.high_band_freq);
	assign inc_th    = low_band ? regs.up_load_low_band : regs.up_load;
	assign up_off    = low_band ? regs.up_offset_low_band : regs.up_offset;
	assign dec_add   = high_band ? HIGH_BAND_DEC_STEP : regs.down_offset;
	assign go_up     = (load_q >= inc_th) && (cur_q < max_q);
	assign go_down   = (load_q < regs.down_load) && (cur_q > min_q);
	assign up_s      = $signed({3'b000, load_q}) + STEP_W'(up_off);
	assign down_s    = $signed({3'b000, PERCENT_FULL}) - $signed({3'b000, load_q})
	                 + $signed({3'b000, dec_add});

	assign prod_d = $signed({{(PROD_W-STEP_W){step_q[STEP_W-1]}}, step_q})
	              * $signed({{(PROD_W-13){1'b0}}, STEP_KHZ});

	// Limit to the maximum first, then raise to the minimum.
	assign tgt_max = (tgt_q > $signed({2'b00, max_q})) ? $signed({2'b00, max_q}) : tgt_q;
	assign tgt_lim = (tgt_max < $signed({2'b00, min_q})) ? $signed({2'b00, min_q}) : tgt_max;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_wall_q <= '0;
			prev_idle_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						prev_wall_q <= s_tdata[63:0];
						prev_idle_q <= s_tdata[127:64];
						state_q     <= ST_PREP;
					end
				end
				ST_PREP:  state_q <= bad_d ? ST_OUT : ST_DIV;
				ST_DIV:   if (div_done) state_q <= ST_DEC;
				ST_DEC:   state_q <= (go_up || go_down) ? ST_MUL : ST_OUT;
				ST_MUL:   state_q <= ST_ADD;
				ST_ADD:   state_q <= ST_CLAMP;
				ST_CLAMP: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				wall_q <= s_tdata[31:0] - prev_wall_q[DELTA_W-1:0];
				idle_q <= s_tdata[95:64] - prev_idle_q[DELTA_W-1:0];
				cur_q  <= s_tdata[150:128];
				min_q  <= s_tdata[173:151];
				max_q  <= s_tdata[196:174];
			end
			ST_PREP: begin
				res_ok_q   <= !bad_d;
				load_q     <= '0;
				act_q      <= ACT_HOLD;
				res_freq_q <= cur_q;
			end
			ST_DIV: begin
				if (div_done)
					load_q <= div_quot;
			end
			ST_DEC: begin
				if (go_up) begin
					act_q  <= ACT_INCREASE;
					step_q <= (up_s == '0) ? STEP_W'(1) : up_s;
				end else if (go_down) begin
					act_q  <= ACT_DECREASE;
					step_q <= (down_s == '0) ? -STEP_W'(1) : -down_s;
				end
			end
			ST_MUL:   prod_q <= prod_d;
			ST_ADD:   tgt_q <= $signed({2'b00, cur_q}) + TGT_W'(prod_q);
			ST_CLAMP: res_freq_q <= tgt_lim[FREQ_W-1:0];
			ST_OUT: begin
				if (out_free) begin
					out_ok_q   <= res_ok_q;
					out_load_q <= load_q;
					out_act_q  <= act_q;
					out_freq_q <= res_freq_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_freq_q, out_act_q, out_load_q, out_ok_q};

	assert property (@(posedge clk) disable iff (!arst_n) in_acc |=> state_q == ST_PREP)
		else $error("accepted item did not enter the delta check");
	assert property (@(posedge clk) disable iff (!arst_n) div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide step");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !out_ok_q |-> out_load_q == '0 && out_act_q == ACT_HOLD)
		else $error("invalid sample carries a decision");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> out_load_q <= PERCENT_FULL)
		else $error("load percentage above full scale");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("waiting result item changed");

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load-based DVFS governor testbench
// Streams cumulative wall and idle counter samples into the governor under
// several register settings and compares every frequency decision with the
// decision worked out independently from the same samples and registers.
// ----------------------------------------------------------------------------
module testbench;
	import dvfs_gov_pkg::*;

	localparam int ITEMS_PER_PHASE = 228;
	localparam int SETTLE_CYCLES   = 60;
	localparam int LONG_HOLD       = 400;
	localparam int REPORT_LIMIT    = 10;

	typedef struct packed {
		logic [FREQ_W-1:0] target;
		logic [1:0]        action;
		logic [LOAD_W-1:0] load;
		logic              ok;
	} decision_t;

	localparam cfg_regs_t RESET_REGS = '{7'd40, 7'd60, 7'd60, 8'h00, 8'h14, 7'd10,
		23'd1728000, 23'd2265600};
	// Nothing ever increases outside the low band, and every load decreases.
	localparam cfg_regs_t ALL_DOWN_REGS = '{7'd0, 7'd127, 7'd127, 8'h80, 8'h80, 7'd0,
		23'd0, 23'h7FFFFF};
	// Almost every frequency is in the low band, with a negative step offset.
	localparam cfg_regs_t ALL_UP_REGS = '{7'd0, 7'd0, 7'd0, 8'hC4, 8'h7F, 7'd127,
		23'h7FFFFF, 23'd0};

	class dvfs_scoreboard;
		cfg_regs_t regs;
		logic [CNT_W-1:0] last_wall;
		logic [CNT_W-1:0] last_idle;
		decision_t decisions_due[$];
		int mismatches;
		int checked;
		int n_up;
		int n_down;
		int n_hold;
		int n_rejected;

		function new();
			regs = RESET_REGS;
			last_wall = '0;
			last_idle = '0;
		endfunction

		function void write_reg(input logic [CFG_IDX_W-1:0] idx,
				input logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_UP_LOAD_LOW_BAND:   regs.up_load_low_band = data[LOAD_W-1:0];
				REG_UP_LOAD:            regs.up_load = data[LOAD_W-1:0];
				REG_DOWN_LOAD:          regs.down_load = data[LOAD_W-1:0];
				REG_UP_OFFSET_LOW_BAND: regs.up_offset_low_band = data[7:0];
				REG_UP_OFFSET:          regs.up_offset = data[7:0];
				REG_DOWN_OFFSET:        regs.down_offset = data[LOAD_W-1:0];
				REG_LOW_BAND_FREQ:      regs.low_band_freq = data[FREQ_W-1:0];
				REG_HIGH_BAND_FREQ:     regs.high_band_freq = data[FREQ_W-1:0];
				default: ;
			endcase
		endfunction

		// Works out the decision for one accepted sample and queues it.
		function void note_sample(input logic [CNT_W-1:0] wall_now, idle_now,
				input logic [FREQ_W-1:0] cur, fmin, fmax);
			logic [CNT_W-1:0] diff;
			logic [DELTA_W-1:0] d_wall;
			logic [DELTA_W-1:0] d_idle;
			longint w, i, busy, s, tgt, c, lo, hi, th, dn, off, add, step;
			decision_t d;

			diff = wall_now - last_wall;
			d_wall = diff[DELTA_W-1:0];
			diff = idle_now - last_idle;
			d_idle = diff[DELTA_W-1:0];
			last_wall = wall_now;
			last_idle = idle_now;
			c = cur;
			lo = fmin;
			hi = fmax;
			step = STEP_KHZ;
			d.ok = 1'b0;
			d.load = '0;
			d.action = ACT_HOLD;
			d.target = cur;
			if (d_wall != 0 && d_wall >= d_idle) begin
				w = d_wall;
				i = d_idle;
				busy = (w - i) * 100 / w;
				th = regs.up_load;
				dn = regs.down_load;
				off = $signed(regs.up_offset);
				add = regs.down_offset;
				if (cur < regs.low_band_freq) begin
					th = regs.up_load_low_band;
					off = $signed(regs.up_offset_low_band);
				end else if (cur > regs.high_band_freq) begin
					add = HIGH_BAND_DEC_STEP;
				end
				d.ok = 1'b1;
				d.load = busy[LOAD_W-1:0];
				tgt = c;
				if (busy >= th && cur < fmax) begin
					s = busy + off;
					if (s == 0)
						s = 1;
					tgt = c + s * step;
					d.action = ACT_INCREASE;
				end else if (busy < dn && cur > fmin) begin
					s = 100 - busy + add;
					if (s == 0)
						s = 1;
					tgt = c - s * step;
					d.action = ACT_DECREASE;
				end
				// The upper limit is applied first, so the lower one wins when they cross.
				if (d.action != ACT_HOLD) begin
					if (tgt > hi)
						tgt = hi;
					if (tgt < lo)
						tgt = lo;
					d.target = tgt[FREQ_W-1:0];
				end
			end
			if (!d.ok)
				n_rejected++;
			else if (d.action == ACT_INCREASE)
				n_up++;
			else if (d.action == ACT_DECREASE)
				n_down++;
			else
				n_hold++;
			decisions_due.push_back(d);
		endfunction

		function void check_decision(input logic [OUT_DATA_W-1:0] word);
			decision_t got;
			decision_t want;

			got = word[$bits(decision_t)-1:0];
			checked++;
			if (decisions_due.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("decision %0d arrived with no sample pending: %h", checked, word);
				return;
			end
			want = decisions_due.pop_front();
			if (got.ok !== want.ok || got.load !== want.load || got.action !== want.action
					|| got.target !== want.target) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("decision %0d: expected ok=%0d load=%0d action=%0d target=%0d, got ok=%0d load=%0d action=%0d target=%0d",
						checked, want.ok, want.load, want.action, want.target,
						got.ok, got.load, got.action, got.target);
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	// wall_now, idle_now, cur_freq, min_freq, max_freq, zero fill
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	// sample_ok, load_percent, action, target_freq, zero fill
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	dvfs_scoreboard sb;
	logic [CNT_W-1:0] wall_at;
	logic [CNT_W-1:0] idle_at;
	bit sender_steady;
	bit ready_always;
	bit hold_off_req;
	int hold_cycles;
	int settings_seen;

	load_based_dvfs_governor i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("Timed out with %0d decisions still pending", sb.decisions_due.size());
		$display("Mismatches found");
		$finish;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int unsigned idle_gap();
		int unsigned r;

		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 60);
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_decision(m_tdata);
	end

	initial begin
		int unsigned gap;

		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_off_req) begin
				m_tready = 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_cycles += LONG_HOLD;
				hold_off_req = 1'b0;
			end else begin
				gap = ready_always ? 0 : idle_gap();
				if (gap > 0) begin
					m_tready = 1'b0;
					repeat (gap) @(negedge clk);
				end
				m_tready = 1'b1;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end
		end
	end

	// Called at a falling edge; cfg_valid is left high for the caller to lower.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1'b1;
		forever begin
			@(posedge clk);
			if (cfg_ready)
				break;
		end
		sb.write_reg(idx, data);
		@(negedge clk);
	endtask

	// Writes every register; with junk set, unused upper data bits carry noise.
	task automatic load_settings(input cfg_regs_t want, input bit junk);
		logic [31:0] n;

		n = junk ? $urandom() : 32'd0;
		write_reg(REG_UP_LOAD_LOW_BAND, {n[15:0], want.up_load_low_band});
		write_reg(REG_UP_LOAD, {n[16:1], want.up_load});
		write_reg(REG_DOWN_LOAD, {n[17:2], want.down_load});
		write_reg(REG_UP_OFFSET_LOW_BAND, {n[14:0], want.up_offset_low_band});
		write_reg(REG_UP_OFFSET, {n[15:1], want.up_offset});
		write_reg(REG_DOWN_OFFSET, {n[18:3], want.down_offset});
		write_reg(REG_LOW_BAND_FREQ, want.low_band_freq);
		write_reg(REG_HIGH_BAND_FREQ, want.high_band_freq);
		cfg_valid = 1'b0;
		settings_seen++;
	endtask

	// Counters advance by the given steps from the last values sent.
	task automatic send_sample(input logic [CNT_W-1:0] w_step, i_step,
			input logic [FREQ_W-1:0] cur, fmin, fmax);
		int unsigned gap;

		gap = sender_steady ? 0 : idle_gap();
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		wall_at = wall_at + w_step;
		idle_at = idle_at + i_step;
		s_tdata = {fmax, fmin, cur, idle_at, wall_at};
		s_tvalid = 1'b1;
		forever begin
			@(posedge clk);
			if (s_tready)
				break;
		end
		sb.note_sample(wall_at, idle_at, cur, fmin, fmax);
		@(negedge clk);
	endtask

	task automatic settle();
		s_tvalid = 1'b0;
		while (sb.decisions_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic random_sample();
		logic [CNT_W-1:0] w_step;
		logic [CNT_W-1:0] i_step;
		logic [FREQ_W-1:0] cur;
		logic [FREQ_W-1:0] fmin;
		logic [FREQ_W-1:0] fmax;
		int unsigned lo, hi, c, d1, d2, pick;

		pick = $urandom_range(0, 99);
		case ($urandom_range(0, 2))
			0: w_step = $urandom_range(1, 200);
			1: w_step = $urandom_range(1000, 1000000);
			default: w_step = {32'd0, $urandom()} | 64'd1;
		endcase
		i_step = w_step - (w_step * $urandom_range(0, 100)) / 100;
		// A minority of broken samples: stalled wall clock, idle running ahead,
		// large jumps in the upper counter bits, or counters from nowhere.
		if (pick >= 88) begin
			case (pick % 4)
				0: w_step = '0;
				1: i_step = w_step + $urandom_range(1, 1000);
				2: begin
					w_step[63:32] = $urandom();
					i_step[63:32] = $urandom();
				end
				default: begin
					wall_at = {$urandom(), $urandom()};
					idle_at = {$urandom(), $urandom()};
				end
			endcase
		end

		lo = sb.regs.low_band_freq;
		hi = sb.regs.high_band_freq;
		case ($urandom_range(0, 5))
			0: cur = $urandom_range(0, lo);
			1: cur = $urandom_range(lo, hi);
			2: cur = $urandom_range(hi, 23'h7FFFFF);
			3: case ($urandom_range(0, 3))
				0: cur = lo - 1;
				1: cur = lo;
				2: cur = hi;
				default: cur = hi + 1;
			endcase
			default: cur = $urandom();
		endcase
		c = cur;
		d1 = $urandom_range(0, 1500000);
		d2 = $urandom_range(0, 1500000);
		fmin = (c > d1) ? c - d1 : 0;
		fmax = (c + d2 > 23'h7FFFFF) ? 23'h7FFFFF : c + d2;
		case ($urandom_range(0, 7))
			0: fmin = cur;
			1: fmax = cur;
			2: begin
				fmin = $urandom();
				fmax = $urandom();
			end
			default: ;
		endcase
		send_sample(w_step, i_step, cur, fmin, fmax);
	endtask

	initial begin
		cfg_regs_t pick_regs;

		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		wall_at = '0;
		idle_at = '0;
		sender_steady = 1'b0;
		ready_always = 1'b0;
		hold_off_req = 1'b0;
		hold_cycles = 0;
		settings_seen = 1;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Registers at their reset values.
		send_sample(0, 0, 1000000, 300000, 2500000);
		send_sample(1000, 2000, 1000000, 300000, 2500000);
		send_sample(1000, 0, 1000000, 300000, 2500000);
		send_sample(1000, 1000, 2000000, 300000, 2500000);
		send_sample(100, 0, 2400000, 300000, 2500000);
		send_sample(100, 100, 2400000, 300000, 2500000);
		send_sample(100, 0, 2500000, 300000, 2500000);
		send_sample(100, 100, 300000, 300000, 2500000);
		send_sample(100, 41, 2000000, 300000, 2500000);
		send_sample(100, 40, 2000000, 300000, 2500000);
		send_sample(100, 60, 1727999, 300000, 2500000);
		send_sample(100, 60, 1728000, 300000, 2500000);
		send_sample(100, 100, 2265600, 300000, 2500000);
		send_sample(100, 100, 2265601, 300000, 2500000);
		send_sample(100, 0, 500000, 3000000, 1000000);
		send_sample(3, 1, 2000000, 0, 23'h7FFFFF);
		send_sample(64'hFFFF_FFFF, 0, 23'h7FFFF0, 0, 23'h7FFFFF);
		send_sample(100, 100, 100, 0, 2500000);
		// Counters that wrap through zero.
		wall_at = 64'hFFFF_FFFF_FFFF_FF00;
		idle_at = 64'hFFFF_FFFF_FFFF_FFF0;
		send_sample(0, 0, 2000000, 300000, 2500000);
		send_sample(64'h200, 64'h80, 2000000, 300000, 2500000);
		settle();

		// Down step that sums to zero at full load.
		load_settings(ALL_DOWN_REGS, 1'b0);
		send_sample(100, 0, 2000000, 0, 2500000);
		send_sample(100, 100, 2000000, 0, 2500000);
		settle();

		// Up step that sums to zero, and a negative up step.
		load_settings(ALL_UP_REGS, 1'b0);
		send_sample(100, 40, 1000000, 0, 5000000);
		send_sample(100, 100, 1000000, 0, 5000000);
		send_sample(100, 0, 23'h7FFFFF, 0, 23'h7FFFFF);
		settle();

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: pick_regs = RESET_REGS;
				1: pick_regs = ALL_DOWN_REGS;
				2: pick_regs = ALL_UP_REGS;
				default: begin
					pick_regs.up_load_low_band = $urandom_range(0, 100);
					pick_regs.up_load = $urandom_range(0, 100);
					pick_regs.down_load = $urandom_range(5, 95);
					pick_regs.up_offset_low_band = $urandom_range(0, 200) - 100;
					pick_regs.up_offset = $urandom_range(0, 200) - 100;
					pick_regs.down_offset = $urandom_range(0, 100);
					pick_regs.low_band_freq = $urandom_range(300000, 2500000);
					pick_regs.high_band_freq =
						$urandom_range(pick_regs.low_band_freq, 3500000);
				end
			endcase
			load_settings(pick_regs, p >= 3);
			sender_steady = (p == 3 || p == 4);
			ready_always = (p == 5);
			// The receiver stalls long enough for the block to back up its input.
			if (p == 4)
				hold_off_req = 1'b1;
			repeat (ITEMS_PER_PHASE) random_sample();
			settle();
		end

		$display("Checked %0d decisions under %0d register settings: %0d up, %0d down, %0d hold, %0d rejected.",
			sb.checked, settings_seen, sb.n_up, sb.n_down, sb.n_hold, sb.n_rejected);
		$display("Output held off for %0d cycles in one stretch while samples kept coming.",
			hold_cycles);
		if (sb.mismatches == 0 && sb.decisions_due.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("%0d mismatching decisions, %0d left pending", sb.mismatches,
				sb.decisions_due.size());
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
